/* hdl/line_follower_recovery_fsm_assert.svh */
// Assertion macros shared by the line follower recovery controller RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef LINE_FOLLOWER_RECOVERY_FSM_ASSERT_SVH
`define LINE_FOLLOWER_RECOVERY_FSM_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfr same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfr next-cycle check failed");

`endif

/* hdl/lfr_pkg.sv */
// Shared codes, widths and beat types of the line follower recovery controller.
// Depends on nothing; imported by every module of the block.
package lfr_pkg;

   localparam int TimeWidth = 32;
   localparam int DurWidth  = 16;
   localparam int CodeWidth = 3;
   localparam int SideWidth = 2;
   localparam int IdxWidth  = 3;

   // robot modes (also the mode field of a result)
   localparam logic [CodeWidth-1:0] MODE_FOLLOW   = 3'd0;
   localparam logic [CodeWidth-1:0] MODE_BRAKE    = 3'd1;
   localparam logic [CodeWidth-1:0] MODE_REVERSE  = 3'd2;
   localparam logic [CodeWidth-1:0] MODE_REVBRAKE = 3'd3;
   localparam logic [CodeWidth-1:0] MODE_SEARCH_L = 3'd4;
   localparam logic [CodeWidth-1:0] MODE_SEARCH_R = 3'd5;
   localparam logic [CodeWidth-1:0] MODE_STOP     = 3'd6;
   localparam logic [CodeWidth-1:0] MODE_STARTING = 3'd7;

   // motor commands
   localparam logic [CodeWidth-1:0] CMD_STOP  = 3'd0;
   localparam logic [CodeWidth-1:0] CMD_FWD   = 3'd1;
   localparam logic [CodeWidth-1:0] CMD_BACK  = 3'd2;
   localparam logic [CodeWidth-1:0] CMD_BRAKE = 3'd3;
   localparam logic [CodeWidth-1:0] CMD_PIV_L = 3'd4;
   localparam logic [CodeWidth-1:0] CMD_PIV_R = 3'd5;

   // sides for first-off latch and last turn
   localparam logic [SideWidth-1:0] SIDE_NONE  = 2'd0;
   localparam logic [SideWidth-1:0] SIDE_LEFT  = 2'd1;
   localparam logic [SideWidth-1:0] SIDE_RIGHT = 2'd2;

   // register indexes
   localparam logic [IdxWidth-1:0] REG_START_DELAY   = 3'd0;
   localparam logic [IdxWidth-1:0] REG_BRAKE_TIME    = 3'd1;
   localparam logic [IdxWidth-1:0] REG_REVERSE_TIME  = 3'd2;
   localparam logic [IdxWidth-1:0] REG_REVBRAKE_TIME = 3'd3;
   localparam logic [IdxWidth-1:0] REG_SEARCH_TMO    = 3'd4;

   // register reset values
   localparam logic [DurWidth-1:0] START_DELAY_RST   = 16'd1000;
   localparam logic [DurWidth-1:0] BRAKE_TIME_RST    = 16'd100;
   localparam logic [DurWidth-1:0] REVERSE_TIME_RST  = 16'd150;
   localparam logic [DurWidth-1:0] REVBRAKE_TIME_RST = 16'd100;
   localparam logic [DurWidth-1:0] SEARCH_TMO_RST    = 16'd2000;

   typedef struct packed {
      logic [DurWidth-1:0] start_wait;
      logic [DurWidth-1:0] brake_span;
      logic [DurWidth-1:0] reverse_span;
      logic [DurWidth-1:0] rev_brake_span;
      logic [DurWidth-1:0] search_limit;
   } cfg_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 hold;
      logic                 left_black;
      logic                 right_black;
   } tick_type;

   typedef struct packed {
      logic [CodeWidth-1:0] drive_command;
      logic [CodeWidth-1:0] mode;
   } result_type;

endpackage

/* hdl/line_follower_recovery_fsm.sv */
// Top level of the line follower recovery controller: beat registers and glue.
// Depends on lfr_pkg, lfr_csr, lfr_ctrl and line_follower_recovery_fsm_assert.svh.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+----------------------------------
//   req_    | in        | req_valid/req_stall | now_ms, hold, left/right_black
//   rsp_    | out       | rsp_valid/rsp_stall | drive_command, mode
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata (16 bits)
//
// A request waits in the request register, then the control update runs into the
// response register. A new beat is taken every cycle while req_stall is low;
// the control state is updated on the same edge that loads the response
// register, so back-to-back ticks see it.
// Reset is synchronous and active high and stands for the init call.
// rsp_stall holds the response register; req_stall rises only when the
// request register is full and cannot drain into a held response.
`include "line_follower_recovery_fsm_assert.svh"

module line_follower_recovery_fsm
   import lfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request beats
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TimeWidth-1:0] req_now_ms,
   input  logic                 req_hold,
   input  logic                 req_left_black,
   input  logic                 req_right_black,
   // response beats
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CodeWidth-1:0] rsp_drive_command,
   output logic [CodeWidth-1:0] rsp_mode,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IdxWidth-1:0]  csr_index,
   input  logic [DurWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   tick_type   tick_ff;
   logic       tick_valid_ff, tick_valid_in;
   result_type rsp_ff, next_result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, xfer, req_take;

   lfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (xfer),
      .tick   (tick_ff),
      .cfg    (cfg),
      .result (next_result)
   );

   // The response register frees up when empty or when its beat leaves now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign xfer      = tick_valid_ff && out_free;
   assign req_stall = tick_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Hold the request while it waits; drop it once it moves on.
   assign tick_valid_in = req_take || (tick_valid_ff && !xfer);
   assign rsp_valid_in  = xfer || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: load on acceptance only.
   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff.now_ms      <= req_now_ms;
         tick_ff.hold        <= req_hold;
         tick_ff.left_black  <= req_left_black;
         tick_ff.right_black <= req_right_black;
      end
      if (xfer) begin
         rsp_ff <= next_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_command = rsp_ff.drive_command;
   assign rsp_mode          = rsp_ff.mode;

   // A paused tick always drives the motors stopped.
   `LFR_ASSERT_NEXT(a_hold_stops, clock, reset, xfer && tick_ff.hold, rsp_drive_command == CMD_STOP)
   // While the start delay runs the motors stay stopped.
   `LFR_ASSERT_NEXT(a_start_stops, clock, reset, xfer && (next_result.mode == MODE_STARTING), rsp_drive_command == CMD_STOP)
   // Backpressure on the request side only while a tick is waiting.
   `LFR_ASSERT_IMPLY(a_stall_needs_tick, clock, reset, !tick_valid_ff, !req_stall)
   // Only defined motor commands leave the block.
   `LFR_ASSERT_IMPLY(a_cmd_legal, clock, reset, rsp_valid_ff, rsp_drive_command <= CMD_PIV_R)

endmodule

/* hdl/lfr_csr.sv */
// Configuration register file of the line follower recovery controller.
// Depends on lfr_pkg for register indexes, reset values and cfg_type.
module lfr_csr
   import lfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IdxWidth-1:0] csr_index,
   input  logic [DurWidth-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_START_DELAY:   cfg_in.start_wait     = csr_wdata;
            REG_BRAKE_TIME:    cfg_in.brake_span     = csr_wdata;
            REG_REVERSE_TIME:  cfg_in.reverse_span   = csr_wdata;
            REG_REVBRAKE_TIME: cfg_in.rev_brake_span = csr_wdata;
            REG_SEARCH_TMO:    cfg_in.search_limit   = csr_wdata;
            default:           cfg_in = cfg_ff; // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_wait     <= START_DELAY_RST;
         cfg_ff.brake_span     <= BRAKE_TIME_RST;
         cfg_ff.reverse_span   <= REVERSE_TIME_RST;
         cfg_ff.rev_brake_span <= REVBRAKE_TIME_RST;
         cfg_ff.search_limit   <= SEARCH_TMO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/lfr_ctrl.sv */
// Recovery state machine: pause handling, start delay, follow and timed recovery.
// Depends on lfr_pkg for codes and the cfg, tick and result types.
module lfr_ctrl
   import lfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  tick_type   tick,
   input  cfg_type    cfg,
   output result_type result
);

   logic [CodeWidth-1:0] mode_ff, mode_in;
   logic                 starting_ff, starting_in;
   logic                 paused_ff, paused_in;
   logic [TimeWidth-1:0] mst_ff, mst_in;
   logic [TimeWidth-1:0] pst_ff, pst_in;
   logic                 prev_l_ff, prev_l_in;
   logic                 prev_r_ff, prev_r_in;
   logic [SideWidth-1:0] fos_ff, fos_in;
   logic [SideWidth-1:0] ltd_ff, ltd_in;
   logic [CodeWidth-1:0] held_ff, held_in;

   logic                 unpause;
   logic [TimeWidth-1:0] elapsed;
   logic                 lb, rb, loff, roff;

   assign lb = tick.left_black;
   assign rb = tick.right_black;
   assign unpause = !tick.hold && paused_ff;
   // On release, now - (mst + now - pst) folds to pst - mst.
   assign elapsed = unpause ? (pst_ff - mst_ff) : (tick.now_ms - mst_ff);

   always_comb begin
      mode_in     = mode_ff;
      starting_in = starting_ff;
      paused_in   = paused_ff;
      mst_in      = mst_ff;
      pst_in      = pst_ff;
      prev_l_in   = prev_l_ff;
      prev_r_in   = prev_r_ff;
      fos_in      = fos_ff;
      ltd_in      = ltd_ff;
      held_in     = held_ff;
      loff        = 1'b0;
      roff        = 1'b0;

      if (tick.hold) begin
         if (!paused_ff) pst_in = tick.now_ms;
         paused_in = 1'b1;
         held_in   = CMD_STOP;
      end else if (paused_ff) begin
         mst_in    = mst_ff + (tick.now_ms - pst_ff);
         paused_in = 1'b0;
      end

      if (paused_in) begin
         held_in = CMD_STOP;
      end else if (starting_ff && (elapsed < TimeWidth'(cfg.start_wait))) begin
         held_in = CMD_STOP;
      end else begin
         if (starting_ff) begin
            // start delay over: take this sample as the previous one
            starting_in = 1'b0;
            mode_in     = MODE_FOLLOW;
            held_in     = CMD_STOP;
         end else begin
            loff = prev_l_ff && !lb;
            roff = prev_r_ff && !rb;
         end

         unique case (mode_in)
            MODE_FOLLOW: begin
               if (fos_in == SIDE_NONE) begin
                  if (loff && !roff)      fos_in = SIDE_LEFT;
                  else if (roff && !loff) fos_in = SIDE_RIGHT;
               end
               if (fos_in == SIDE_LEFT)       ltd_in = SIDE_RIGHT;
               else if (fos_in == SIDE_RIGHT) ltd_in = SIDE_LEFT;
               if (lb && rb) begin
                  fos_in  = SIDE_NONE;
                  held_in = CMD_FWD;
               end else if (lb) begin
                  if (fos_in == SIDE_NONE) fos_in = SIDE_RIGHT;
                  if (fos_in == SIDE_RIGHT) begin
                     ltd_in  = SIDE_LEFT;
                     held_in = CMD_PIV_L;
                  end else begin
                     ltd_in  = SIDE_RIGHT;
                     held_in = CMD_PIV_R;
                  end
               end else if (rb) begin
                  if (fos_in == SIDE_NONE) fos_in = SIDE_LEFT;
                  if (fos_in == SIDE_LEFT) begin
                     ltd_in  = SIDE_RIGHT;
                     held_in = CMD_PIV_R;
                  end else begin
                     ltd_in  = SIDE_LEFT;
                     held_in = CMD_PIV_L;
                  end
               end else begin
                  held_in = CMD_BRAKE;
                  mode_in = MODE_BRAKE;
                  mst_in  = tick.now_ms;
               end
            end
            MODE_BRAKE: begin
               held_in = CMD_BRAKE;
               if (elapsed >= TimeWidth'(cfg.brake_span)) begin
                  held_in = CMD_BACK;
                  mode_in = MODE_REVERSE;
                  mst_in  = tick.now_ms;
               end
            end
            MODE_REVERSE: begin
               held_in = CMD_BACK;
               if (elapsed >= TimeWidth'(cfg.reverse_span)) begin
                  held_in = CMD_BRAKE;
                  mode_in = MODE_REVBRAKE;
                  mst_in  = tick.now_ms;
               end
            end
            MODE_REVBRAKE: begin
               held_in = CMD_BRAKE;
               if (elapsed >= TimeWidth'(cfg.rev_brake_span)) begin
                  mst_in = tick.now_ms;
                  if (ltd_ff == SIDE_LEFT) begin
                     held_in = CMD_PIV_L;
                     mode_in = MODE_SEARCH_L;
                  end else if (ltd_ff == SIDE_RIGHT) begin
                     held_in = CMD_PIV_R;
                     mode_in = MODE_SEARCH_R;
                  end else begin
                     held_in = CMD_STOP;
                     mode_in = MODE_STOP;
                  end
               end
            end
            MODE_SEARCH_L, MODE_SEARCH_R: begin
               if (lb || rb) begin
                  mode_in = MODE_FOLLOW; // keep the pivot command one more tick
               end else begin
                  held_in = (mode_ff == MODE_SEARCH_L) ? CMD_PIV_L : CMD_PIV_R;
                  if (elapsed >= TimeWidth'(cfg.search_limit)) begin
                     held_in = CMD_STOP;
                     mode_in = MODE_STOP;
                  end
               end
            end
            MODE_STOP: begin
               held_in = CMD_STOP;
               if (lb || rb) begin
                  fos_in  = SIDE_NONE;
                  mode_in = MODE_FOLLOW;
               end
            end
            default: begin
               held_in = CMD_STOP;
               mode_in = MODE_STOP;
            end
         endcase
         prev_l_in = lb;
         prev_r_in = rb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_STOP;
         starting_ff <= 1'b1;
         paused_ff   <= 1'b0;
         mst_ff      <= '0;
         pst_ff      <= '0;
         prev_l_ff   <= 1'b0;
         prev_r_ff   <= 1'b0;
         fos_ff      <= SIDE_NONE;
         ltd_ff      <= SIDE_NONE;
         held_ff     <= CMD_STOP;
      end else if (fire) begin
         mode_ff     <= mode_in;
         starting_ff <= starting_in;
         paused_ff   <= paused_in;
         mst_ff      <= mst_in;
         pst_ff      <= pst_in;
         prev_l_ff   <= prev_l_in;
         prev_r_ff   <= prev_r_in;
         fos_ff      <= fos_in;
         ltd_ff      <= ltd_in;
         held_ff     <= held_in;
      end
   end

   assign result.drive_command = held_in;
   assign result.mode          = starting_in ? MODE_STARTING : mode_in;

endmodule
